// ===== src/osd_pkg.sv =====
// osd_pkg: shared constants, request codes and the result record of the
// osd text line generator. Depends on nothing; every other file imports it.
package osd_pkg;

  // default geometry of the character store
  localparam int unsigned ROWS_DEF    = 16;
  localparam int unsigned COLUMNS_DEF = 24;

  // field widths
  localparam int unsigned TYPE_W  = 2;
  localparam int unsigned ADDR_W  = 11;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned LINE_W  = 10;
  localparam int unsigned FRAME_W = 16;
  localparam int unsigned FTIME_W = 32;
  localparam int unsigned FROW_W  = 3;

  // font store: 256 characters of 8 rows
  localparam int unsigned FONT_DEPTH = 2048;

  // lines per character row and reset value of the window start
  localparam int unsigned LINES_PER_ROW = 16;
  localparam logic [LINE_W-1:0] WIN_START_RST = LINE_W'(32);
  localparam logic [LINE_W-1:0] LINE_MAX      = LINE_W'(1023);

  // request codes
  localparam logic [TYPE_W-1:0] REQ_CELL  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_FONT  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_LINE  = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_FRAME = 2'd3;

  // result kinds
  localparam logic KIND_PIXEL  = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  // one result item
  typedef struct packed {
    logic               result_kind;
    logic [BYTE_W-1:0]  pixel_byte;
    logic               overlay_enable;
    logic               last;
    logic [LINE_W-1:0]  lines_in_frame;
    logic [FRAME_W-1:0] frame_number;
    logic [FTIME_W-1:0] frame_time;
  } res_t;

endpackage

// ===== src/osd_if.sv =====
// osd_if: valid/ready channel interfaces for requests, results and the
// window start register. Depends on osd_pkg.
interface osd_req_if;
  import osd_pkg::*;
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  req_type;
  logic [ADDR_W-1:0]  address;
  logic [BYTE_W-1:0]  write_data;
  logic [TIMER_W-1:0] timer_value;
  modport source(output valid, req_type, address, write_data, timer_value, input ready);
  modport sink(input valid, req_type, address, write_data, timer_value, output ready);
endinterface

interface osd_res_if;
  import osd_pkg::*;
  logic               valid;
  logic               ready;
  logic               result_kind;
  logic [BYTE_W-1:0]  pixel_byte;
  logic               overlay_enable;
  logic               last;
  logic [LINE_W-1:0]  lines_in_frame;
  logic [FRAME_W-1:0] frame_number;
  logic [FTIME_W-1:0] frame_time;
  modport source(output valid, result_kind, pixel_byte, overlay_enable, last,
                 lines_in_frame, frame_number, frame_time, input ready);
  modport sink(input valid, result_kind, pixel_byte, overlay_enable, last,
               lines_in_frame, frame_number, frame_time, output ready);
endinterface

interface osd_cfg_if;
  import osd_pkg::*;
  logic              valid;
  logic              ready;
  logic [LINE_W-1:0] win_start;
  modport source(output valid, win_start, input ready);
  modport sink(input valid, win_start, output ready);
endinterface

// ===== src/osd_store.sv =====
// osd_store: character cell memory (cleared by a sweep after reset) and font
// memory, both with one write port and one registered read port.
// Depends on osd_pkg.
module osd_store #(
  parameter int unsigned ROWS    = osd_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = osd_pkg::COLUMNS_DEF,
  localparam int unsigned CELL_DEPTH = ROWS * COLUMNS,
  localparam int unsigned CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cell_we_i,
  input  logic [CELL_AW-1:0]         cell_waddr_i,
  input  logic [osd_pkg::BYTE_W-1:0] cell_wdata_i,
  input  logic                       cell_re_i,
  input  logic [CELL_AW-1:0]         cell_raddr_i,
  output logic [osd_pkg::BYTE_W-1:0] cell_rdata_o,
  input  logic                       font_we_i,
  input  logic [osd_pkg::ADDR_W-1:0] font_waddr_i,
  input  logic [osd_pkg::BYTE_W-1:0] font_wdata_i,
  input  logic                       font_re_i,
  input  logic [osd_pkg::ADDR_W-1:0] font_raddr_i,
  output logic [osd_pkg::BYTE_W-1:0] font_rdata_o,
  output logic                       busy_o
);
  import osd_pkg::*;

  logic [BYTE_W-1:0] cells [CELL_DEPTH];
  logic [BYTE_W-1:0] font  [FONT_DEPTH];

  logic               clr_busy_q, clr_busy_d;
  logic [CELL_AW-1:0] clr_idx_q, clr_idx_d;
  logic               cell_wen;
  logic [CELL_AW-1:0] cell_wa;
  logic [BYTE_W-1:0]  cell_wd;
  logic [BYTE_W-1:0]  cell_rdata_q;
  logic [BYTE_W-1:0]  font_rdata_q;

  // clearing sweep, one cell per cycle after reset
  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_idx_d  = clr_idx_q;
    if (clr_busy_q) begin
      if (clr_idx_q == CELL_AW'(CELL_DEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end else begin
        clr_idx_d = clr_idx_q + CELL_AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  // cell write port shared between sweep and requests
  assign cell_wen = clr_busy_q | cell_we_i;
  assign cell_wa  = clr_busy_q ? clr_idx_q : cell_waddr_i;
  assign cell_wd  = clr_busy_q ? '0 : cell_wdata_i;

  // cell memory
  always_ff @(posedge clk_i) begin
    if (cell_wen) begin
      cells[cell_wa] <= cell_wd;
    end
    if (cell_re_i) begin
      cell_rdata_q <= cells[cell_raddr_i];
    end
  end

  // font memory
  always_ff @(posedge clk_i) begin
    if (font_we_i) begin
      font[font_waddr_i] <= font_wdata_i;
    end
    if (font_re_i) begin
      font_rdata_q <= font[font_raddr_i];
    end
  end

  assign cell_rdata_o = cell_rdata_q;
  assign font_rdata_o = font_rdata_q;
  assign busy_o       = clr_busy_q;

endmodule

// ===== src/osd_text_line_generator.sv =====
// osd_text_line_generator: text overlay line generator on osd_store; uses osd_pkg, osd_if.
// A write gives no result; a frame sync or a line sync outside the window gives one last
// result; a line sync inside the window gives one column per cycle through cell read, font
// read and output register, then the last result; a stalled result output stalls the
// sequencer. One request at a time. Reset initialises all control state; the cell memory
// is then cleared and no request is taken; window start writes are taken at any time.
module osd_text_line_generator #(
  parameter int unsigned ROWS    = osd_pkg::ROWS_DEF,
  parameter int unsigned COLUMNS = osd_pkg::COLUMNS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  osd_req_if.sink   req_i,
  osd_res_if.source res_o,
  osd_cfg_if.sink   cfg_i
);
  import osd_pkg::*;

  localparam int unsigned CELL_DEPTH = ROWS * COLUMNS;
  localparam int unsigned CELL_AW    = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
  localparam int unsigned ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned COL_W      = $clog2(COLUMNS + 1);
  localparam int unsigned WIN_LINES  = ROWS * LINES_PER_ROW;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LINE  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [LINE_W-1:0]  win_start_q;
  logic [LINE_W-1:0]  line_count_q, line_count_d;
  logic [FRAME_W-1:0] frame_cnt_q, frame_cnt_d;
  logic [TIMER_W-1:0] tlast_q, tlast_d;
  logic [TIMER_W-1:0] twraps_q, twraps_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               v1_q, v1_d, v2_q, v2_d;
  logic               en2_q, en2_d;
  logic [CELL_AW-1:0] base_q, base_d;
  logic [FROW_W-1:0]  frow_q, frow_d;
  res_t               pend_q, pend_d;
  res_t               res_q, out_d;
  logic               res_valid_q, res_valid_d;
  logic               out_load;
  logic               adv;
  logic               accept;

  logic [LINE_W-1:0]  ln;
  logic               in_win;
  logic [ROW_W-1:0]   row_sel;
  logic [FRAME_W-1:0] fc_new;
  logic [TIMER_W-1:0] wr_new;

  logic                store_busy;
  logic                cell_we, cell_re, font_we, font_re;
  logic [CELL_AW-1:0]  cell_raddr;
  logic [BYTE_W-1:0]   cell_rdata, font_rdata;
  logic [ADDR_W-1:0]   font_raddr;

  // memories
  osd_store #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cell_we_i    (cell_we),
    .cell_waddr_i (req_i.address[CELL_AW-1:0]),
    .cell_wdata_i (req_i.write_data),
    .cell_re_i    (cell_re),
    .cell_raddr_i (cell_raddr),
    .cell_rdata_o (cell_rdata),
    .font_we_i    (font_we),
    .font_waddr_i (req_i.address),
    .font_wdata_i (req_i.write_data),
    .font_re_i    (font_re),
    .font_raddr_i (font_raddr),
    .font_rdata_o (font_rdata),
    .busy_o       (store_busy)
  );

  // handshakes
  assign req_i.ready = (state_q == ST_IDLE) && !store_busy;
  assign accept      = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;
  assign adv         = !res_valid_q || res_o.ready;

  // window position of the current line
  assign ln      = line_count_q - win_start_q;
  assign in_win  = (line_count_q >= win_start_q) && (ln < LINE_W'(WIN_LINES));
  assign row_sel = ln[4 +: ROW_W];

  // frame counters after this frame sync
  assign fc_new = frame_cnt_q + FRAME_W'(1);
  assign wr_new = (req_i.timer_value < tlast_q) ? twraps_q + TIMER_W'(1) : twraps_q;

  // write ports
  assign cell_we = accept && (req_i.req_type == REQ_CELL) &&
                   (req_i.address < ADDR_W'(CELL_DEPTH));
  assign font_we = accept && (req_i.req_type == REQ_FONT);

  // fetch pipeline read ports
  assign cell_raddr = CELL_AW'(base_q + CELL_AW'(col_q));
  assign cell_re    = (state_q == ST_LINE) && adv && (col_q < COL_W'(COLUMNS));
  assign font_raddr = {cell_rdata, frow_q};
  assign font_re    = (state_q == ST_LINE) && adv && v1_q;

  // sequencer
  always_comb begin
    state_d      = state_q;
    line_count_d = line_count_q;
    frame_cnt_d  = frame_cnt_q;
    tlast_d      = tlast_q;
    twraps_d     = twraps_q;
    col_d        = col_q;
    v1_d         = v1_q;
    v2_d         = v2_q;
    en2_d        = en2_q;
    base_d       = base_q;
    frow_d       = frow_q;
    pend_d       = pend_q;
    out_load     = 1'b0;
    out_d        = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.req_type)
            REQ_LINE: begin
              pend_d                = '0;
              pend_d.result_kind    = KIND_PIXEL;
              pend_d.overlay_enable = 1'b1;
              pend_d.last           = 1'b1;
              if (line_count_q < LINE_MAX) begin
                line_count_d = line_count_q + LINE_W'(1);
              end
              base_d  = CELL_AW'(32'(row_sel) * COLUMNS);
              frow_d  = ln[3:1];
              col_d   = '0;
              state_d = in_win ? ST_LINE : ST_FLUSH;
            end
            REQ_FRAME: begin
              pend_d                = '0;
              pend_d.result_kind    = KIND_REPORT;
              pend_d.last           = 1'b1;
              pend_d.lines_in_frame = line_count_q;
              pend_d.frame_number   = fc_new;
              pend_d.frame_time     = {wr_new, req_i.timer_value};
              frame_cnt_d  = fc_new;
              twraps_d     = wr_new;
              tlast_d      = req_i.timer_value;
              line_count_d = '0;
              state_d      = ST_FLUSH;
            end
            default: begin
            end
          endcase
        end
      end
      ST_LINE: begin
        if (adv) begin
          // output stage
          if (v2_q) begin
            out_load             = 1'b1;
            out_d.result_kind    = KIND_PIXEL;
            out_d.pixel_byte     = font_rdata;
            out_d.overlay_enable = en2_q;
          end
          // font read stage
          v2_d  = v1_q;
          en2_d = cell_rdata[BYTE_W-1];
          // cell read stage
          v1_d = cell_re;
          if (cell_re) begin
            col_d = col_q + COL_W'(1);
          end
        end
        if ((col_q == COL_W'(COLUMNS)) && !v1_q && !v2_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (adv) begin
          out_load = 1'b1;
          out_d    = pend_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // result register
  assign res_valid_d = out_load ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      win_start_q  <= WIN_START_RST;
      line_count_q <= '0;
      frame_cnt_q  <= '0;
      tlast_q      <= '0;
      twraps_q     <= '0;
      col_q        <= '0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      line_count_q <= line_count_d;
      frame_cnt_q  <= frame_cnt_d;
      tlast_q      <= tlast_d;
      twraps_q     <= twraps_d;
      col_q        <= col_d;
      v1_q         <= v1_d;
      v2_q         <= v2_d;
      res_valid_q  <= res_valid_d;
      if (cfg_i.valid) begin
        win_start_q <= cfg_i.win_start;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    en2_q  <= en2_d;
    base_q <= base_d;
    frow_q <= frow_d;
    pend_q <= pend_d;
    if (out_load) begin
      res_q <= out_d;
    end
  end

  // result port
  assign res_o.valid          = res_valid_q;
  assign res_o.result_kind    = res_q.result_kind;
  assign res_o.pixel_byte     = res_q.pixel_byte;
  assign res_o.overlay_enable = res_q.overlay_enable;
  assign res_o.last           = res_q.last;
  assign res_o.lines_in_frame = res_q.lines_in_frame;
  assign res_o.frame_number   = res_q.frame_number;
  assign res_o.frame_time     = res_q.frame_time;

  // checks
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_busy |-> !req_i.ready)
    else $error("request taken during cell clearing");

  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!v1_q && !v2_q))
    else $error("fetch pipeline not empty in idle");

  a_stall_holds_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_LINE) && !adv) |=> ($stable(col_q) && $stable(v1_q) && $stable(v2_q)))
    else $error("fetch pipeline moved during output stall");

  a_last_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_d.last) |=> (state_q == ST_IDLE))
    else $error("final result loaded without returning to idle");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COL_W'(COLUMNS))
    else $error("column counter out of range");

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for osd_text_line_generator, with a scoreboard
// class that mirrors the character store, font and counters to predict each byte.
// Depends on osd_pkg, osd_if (request, result and window start channels) and the dut.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import osd_pkg::*;

  localparam int unsigned CELLS         = ROWS_DEF * COLUMNS_DEF;
  localparam int unsigned CELL_AW       = $clog2(CELLS);
  localparam int unsigned WINDOW_LINES  = ROWS_DEF * LINES_PER_ROW;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned RANDOM_ITEMS  = 15;
  localparam int unsigned LINE_SYNCS    = 16;

  // predicts every output of the generator from the accepted requests
  class osd_line_scoreboard;
    logic [BYTE_W-1:0]  cells [CELLS];
    logic [BYTE_W-1:0]  glyphs [FONT_DEPTH];
    logic [LINE_W-1:0]  line_count;
    logic [LINE_W-1:0]  window_start;
    logic [FRAME_W-1:0] frames_seen;
    logic [TIMER_W-1:0] timer_last;
    logic [TIMER_W-1:0] timer_wraps;
    res_t               due_outputs[$];
    int unsigned        failures;

    function new();
      foreach (cells[i]) cells[i] = '0;
      foreach (glyphs[i]) glyphs[i] = '0;
      line_count   = '0;
      window_start = WIN_START_RST;
      frames_seen  = '0;
      timer_last   = '0;
      timer_wraps  = '0;
      failures     = 0;
    endfunction

    function void set_window_start(logic [LINE_W-1:0] value);
      window_start = value;
    endfunction

    function int unsigned due_count();
      return due_outputs.size();
    endfunction

    // work out the outputs that one accepted request causes
    function void render_request(logic [TYPE_W-1:0] kind, logic [ADDR_W-1:0] addr,
                                 logic [BYTE_W-1:0] data, logic [TIMER_W-1:0] tval);
      int unsigned       lc;
      int unsigned       fl;
      int unsigned       ln;
      int unsigned       row;
      logic [2:0]        frow;
      logic [BYTE_W-1:0] code;
      res_t              r;
      lc = line_count;
      fl = window_start;
      case (kind)
        REQ_CELL: begin
          if (addr < CELLS) cells[CELL_AW'(addr)] = data;
        end
        REQ_FONT: begin
          glyphs[addr] = data;
        end
        REQ_LINE: begin
          // one byte per column while inside the text window
          if (lc >= fl && lc - fl < WINDOW_LINES) begin
            ln   = lc - fl;
            row  = ln >> 4;
            frow = 3'((ln >> 1) & 7);
            for (int col = 0; col < COLUMNS_DEF; col++) begin
              code             = cells[CELL_AW'(row * COLUMNS_DEF + col)];
              r                = '0;
              r.result_kind    = KIND_PIXEL;
              r.pixel_byte     = glyphs[{code, frow}];
              r.overlay_enable = code[7];
              due_outputs.push_back(r);
            end
          end
          if (line_count != LINE_MAX) line_count = line_count + LINE_W'(1);
          // trailing blank closes every line
          r                = '0;
          r.result_kind    = KIND_PIXEL;
          r.overlay_enable = 1'b1;
          r.last           = 1'b1;
          due_outputs.push_back(r);
        end
        default: begin
          // frame report, timer extended on wrap
          frames_seen = frames_seen + FRAME_W'(1);
          if (tval < timer_last) timer_wraps = timer_wraps + TIMER_W'(1);
          timer_last       = tval;
          r                = '0;
          r.result_kind    = KIND_REPORT;
          r.last           = 1'b1;
          r.lines_in_frame = line_count;
          r.frame_number   = frames_seen;
          r.frame_time     = {timer_wraps, tval};
          due_outputs.push_back(r);
          line_count = '0;
        end
      endcase
    endfunction

    function void check_field(string name, logic [FTIME_W-1:0] want,
                              logic [FTIME_W-1:0] got);
      if (want !== got) begin
        if (failures < 10)
          $display("mismatch on %s: expected 0x%0h, actual 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    // compare one output against the oldest prediction
    function void compare_output(res_t got);
      res_t want;
      if (due_outputs.size() == 0) begin
        if (failures < 10)
          $display("unexpected output: kind %0d byte 0x%0h last %0d",
                   got.result_kind, got.pixel_byte, got.last);
        failures++;
        return;
      end
      want = due_outputs.pop_front();
      check_field("result_kind", FTIME_W'(want.result_kind), FTIME_W'(got.result_kind));
      check_field("pixel_byte", FTIME_W'(want.pixel_byte), FTIME_W'(got.pixel_byte));
      check_field("overlay_enable", FTIME_W'(want.overlay_enable),
                  FTIME_W'(got.overlay_enable));
      check_field("last", FTIME_W'(want.last), FTIME_W'(got.last));
      check_field("lines_in_frame", FTIME_W'(want.lines_in_frame),
                  FTIME_W'(got.lines_in_frame));
      check_field("frame_number", FTIME_W'(want.frame_number), FTIME_W'(got.frame_number));
      check_field("frame_time", want.frame_time, got.frame_time);
    endfunction

    function void check_drained();
      if (due_outputs.size() != 0) begin
        if (failures < 10)
          $display("%0d predicted outputs never arrived", due_outputs.size());
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned quiet_cycles;
  logic [BYTE_W-1:0] glyph_codes[$];
  osd_line_scoreboard sb;

  osd_req_if req_bus ();
  osd_res_if res_bus ();
  osd_cfg_if cfg_bus ();

  osd_text_line_generator dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_bus),
    .res_o  (res_bus),
    .cfg_i  (cfg_bus)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result receiver with random stalls
  always @(negedge clk) begin
    res_bus.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready)
      sb.compare_output('{result_kind: res_bus.result_kind, pixel_byte: res_bus.pixel_byte,
                          overlay_enable: res_bus.overlay_enable, last: res_bus.last,
                          lines_in_frame: res_bus.lines_in_frame,
                          frame_number: res_bus.frame_number,
                          frame_time: res_bus.frame_time});
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (req_bus.valid && req_bus.ready) || (res_bus.valid && res_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // send one request, called and returning at a falling edge
  task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [ADDR_W-1:0] addr,
                              input logic [BYTE_W-1:0] data,
                              input logic [TIMER_W-1:0] tval);
    while ($urandom_range(0, 99) < send_idle) begin
      req_bus.valid = 1'b0;
      @(negedge clk);
    end
    req_bus.valid       = 1'b1;
    req_bus.req_type    = kind;
    req_bus.address     = addr;
    req_bus.write_data  = data;
    req_bus.timer_value = tval;
    do @(posedge clk); while (!req_bus.ready);
    sb.render_request(kind, addr, data, tval);
    @(negedge clk);
  endtask

  // line or frame sync with random content in the unused fields
  task automatic send_sync(input logic [TYPE_W-1:0] kind);
    send_request(kind, ADDR_W'($urandom), BYTE_W'($urandom), TIMER_W'($urandom));
  endtask

  // fill all eight rows of one character so that cells may use it
  task automatic load_glyph(input logic [BYTE_W-1:0] code);
    for (int r = 0; r < 8; r++)
      send_request(REQ_FONT, {code, 3'(r)}, BYTE_W'($urandom), TIMER_W'($urandom));
    foreach (glyph_codes[i]) if (glyph_codes[i] == code) return;
    glyph_codes.push_back(code);
  endtask

  // window start change, only with the generator drained
  task automatic write_window_start(input logic [LINE_W-1:0] value);
    req_bus.valid = 1'b0;
    while (sb.due_count() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_bus.valid     = 1'b1;
    cfg_bus.win_start = value;
    do @(posedge clk); while (!cfg_bus.ready);
    sb.set_window_start(value);
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // mixed traffic: glyph loads, cell writes, stray font writes and syncs
  task automatic random_traffic(input int unsigned count);
    int unsigned       pick;
    logic [ADDR_W-1:0] addr;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        load_glyph(BYTE_W'($urandom));
      end else if (pick < 24) begin
        if ($urandom_range(0, 9) == 0) addr = ADDR_W'($urandom);
        else addr = ADDR_W'($urandom_range(0, CELLS - 1));
        send_request(REQ_CELL, addr, glyph_codes[$urandom_range(0, glyph_codes.size() - 1)],
                     TIMER_W'($urandom));
      end else if (pick < 32) begin
        send_request(REQ_FONT, ADDR_W'($urandom), BYTE_W'($urandom), TIMER_W'($urandom));
      end else if (pick < 85) begin
        send_sync(REQ_LINE);
      end else begin
        send_sync(REQ_FRAME);
      end
    end
  endtask

  // main sequence
  initial begin
    logic [BYTE_W-1:0] zero_rows [8];
    logic [BYTE_W-1:0] full_rows [8];
    zero_rows = '{8'h00, 8'hff, 8'h80, 8'h01, 8'h55, 8'haa, 8'h3c, 8'hc3};
    full_rows = '{8'hff, 8'h00, 8'h81, 8'h7e, 8'h0f, 8'hf0, 8'h18, 8'he7};
    sb                  = new();
    send_idle           = 35;
    recv_idle           = 49;
    rst_n               = 1'b0;
    req_bus.valid       = 1'b0;
    req_bus.req_type    = REQ_CELL;
    req_bus.address     = '0;
    req_bus.write_data  = '0;
    req_bus.timer_value = '0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.win_start   = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // directed: fonts of the blank and full codes, store edges, timer wrap
    for (int r = 0; r < 8; r++)
      send_request(REQ_FONT, {8'h00, 3'(r)}, zero_rows[r], '0);
    for (int r = 0; r < 8; r++)
      send_request(REQ_FONT, {8'hff, 3'(r)}, full_rows[r], 16'hffff);
    glyph_codes = '{8'h00, 8'hff};
    send_request(REQ_CELL, '0, 8'hff, '0);
    send_request(REQ_CELL, ADDR_W'(CELLS - 1), 8'hff, '0);
    send_request(REQ_CELL, ADDR_W'(CELLS), 8'hff, '0);
    send_request(REQ_CELL, '1, 8'h7f, '0);
    send_request(REQ_FRAME, '0, '0, 16'hffff);
    send_request(REQ_LINE, '1, '1, '1);
    send_request(REQ_FRAME, '1, '1, 16'h0000);
    send_request(REQ_LINE, '0, '0, '0);
    send_request(REQ_FRAME, '0, '0, 16'h0000);

    // window at line zero: every line inside the window from the first sync
    write_window_start('0);
    repeat (LINE_SYNCS) send_sync(REQ_LINE);
    send_sync(REQ_FRAME);
    random_traffic(RANDOM_ITEMS);

    // window a few lines down: lines outside it, then inside
    write_window_start(LINE_W'($urandom_range(3, 10)));
    send_idle = 49;
    recv_idle = 35;
    send_sync(REQ_FRAME);
    repeat (LINE_SYNCS) send_sync(REQ_LINE);
    random_traffic(RANDOM_ITEMS);

    // random window start, no idling on either side
    write_window_start(LINE_W'($urandom_range(1, 8)));
    send_idle = 0;
    recv_idle = 0;
    send_sync(REQ_FRAME);
    random_traffic(RANDOM_ITEMS);

    // drain and settle
    req_bus.valid = 1'b0;
    while (sb.due_count() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    sb.check_drained();
    if (sb.failures == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
